// File: rtl/core/pbkdf2_hmac_sha1_byte_stream_defines.svh
// Assertion macros for the PBKDF2 HMAC-SHA1 byte stream block.
// Included by RTL files that carry concurrent checks.
`ifndef PBKDF2_HMAC_SHA1_BYTE_STREAM_DEFINES_SVH
`define PBKDF2_HMAC_SHA1_BYTE_STREAM_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PHS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: implication");
// next-cycle implication
`define PHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");
`else
`define PHS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PHS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/phs_pkg.sv
// Shared constants, types and functions for the PBKDF2 HMAC-SHA1 byte stream.
// No dependencies.
`timescale 1ns / 1ps
package phs_pkg;
   localparam int MAX_REQUEST_BYTES = 64;
   localparam int KEY_WORDS         = 8;
   localparam int HASH_BYTES        = 20;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_REQ     = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [1:0] CSR_SALT  = 2'd0;
   localparam logic [1:0] CSR_ITERS = 2'd1;
   localparam logic [1:0] CSR_MODE  = 2'd2;

   // compression jobs
   localparam logic [1:0] PH_KEY_IN  = 2'd0;
   localparam logic [1:0] PH_KEY_OUT = 2'd1;
   localparam logic [1:0] PH_INNER   = 2'd2;
   localparam logic [1:0] PH_OUTER   = 2'd3;

   localparam logic [159:0] SHA1_IV =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

   typedef struct packed {
      logic       load;
      logic       restart;
      logic       req_start;
      logic       sha_go;
      logic [1:0] phase;
      logic       blk_begin;
      logic       iter_next;
      logic       blk_end;
      logic       pop;
   } phs_cmd_type;

   typedef struct packed {
      logic sha_done;
      logic last_iter;
      logic buf_empty;
      logic last_out;
   } phs_status_type;

   function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20)      k = 32'h5A827999;
      else if (rnd < 7'd40) k = 32'h6ED9EBA1;
      else if (rnd < 7'd60) k = 32'h8F1BBCDC;
      else                  k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic logic [6:0] sat_count(input logic [6:0] bc);
      logic [6:0] c;
      c = (bc > 7'(MAX_REQUEST_BYTES)) ? 7'(MAX_REQUEST_BYTES) : bc;
      return c;
   endfunction
endpackage

// File: rtl/core/phs_if.sv
// Request and response channel interfaces (valid/ready) of the byte stream.
// Depends on nothing.
`timescale 1ns / 1ps
interface phs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [2:0]  key_word_index;
   logic [63:0] key_word;
   logic [6:0]  byte_count;
   modport source (output valid, op, key_word_index, key_word, byte_count, input ready);
   modport sink   (input valid, op, key_word_index, key_word, byte_count, output ready);
endinterface

interface phs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;
   modport source (output valid, out_byte, last_byte, input ready);
   modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// File: rtl/core/phs_sha1_core.sv
// SHA-1 compression unit: one round per cycle, 80 rounds per block.
// Depends on phs_pkg.
`timescale 1ns / 1ps
module phs_sha1_core
   import phs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [159:0] h_in,
   input  logic [511:0] blk,
   output logic         done,
   output logic [159:0] h_out
);
   logic [31:0]  w_ff [16];
   logic [31:0]  w_in [16];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [159:0] hs_ff, hs_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  f, t, x;

   always_comb begin
      if (rnd_ff < 7'd20)      f = (b_ff & c_ff) | (~b_ff & d_ff);
      else if (rnd_ff < 7'd40) f = b_ff ^ c_ff ^ d_ff;
      else if (rnd_ff < 7'd60) f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
      else                     f = b_ff ^ c_ff ^ d_ff;
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + sha1_k(rnd_ff) + w_ff[0];
      x = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];

      w_in = w_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      hs_in = hs_ff; rnd_in = rnd_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         for (int i = 0; i < 16; i++) w_in[i] = blk[511 - 32*i -: 32];
         {a_in, b_in, c_in, d_in, e_in} = h_in;
         hs_in   = h_in;
         rnd_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = {x[30:0], x[31]};
         a_in = t; b_in = a_ff; c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff; e_in = d_ff;
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'd79) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      hs_ff <= hs_in;
      rnd_ff <= rnd_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign h_out = {hs_ff[159:128] + a_ff, hs_ff[127:96] + b_ff, hs_ff[95:64] + c_ff,
                   hs_ff[63:32] + d_ff, hs_ff[31:0] + e_ff};
endmodule

// File: rtl/core/phs_datapath.sv
// Datapath: password, settings, HMAC chaining states, block buffer, counters.
// Depends on phs_pkg and phs_sha1_core.
`timescale 1ns / 1ps
module phs_datapath
   import phs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  phs_cmd_type    cmd,
   output phs_status_type status,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [63:0]    csr_wdata,
   input  logic [2:0]     key_word_index,
   input  logic [63:0]    key_word,
   input  logic [6:0]     byte_count,
   output logic [7:0]     out_byte
);
   logic [63:0]  pw_ff [KEY_WORDS];
   logic [63:0]  salt_ff;
   logic [31:0]  iters_ff;
   logic         mode_ff;
   logic [31:0]  ctr_ff;
   logic [31:0]  iter_ff;
   logic [4:0]   ptr_ff;
   logic [6:0]   rem_ff;
   logic [159:0] istate_ff, ostate_ff, inner_ff, u_ff, acc_ff;
   logic [511:0] key, blk;
   logic [63:0]  salt_rev;
   logic [159:0] h_in, h_out, shifted;
   logic         sha_done;

   always_comb begin
      for (int i = 0; i < KEY_WORDS; i++) key[511 - 64*i -: 64] = pw_ff[i];
      for (int i = 0; i < 8; i++) salt_rev[63 - 8*i -: 8] = salt_ff[8*i +: 8];
      case (cmd.phase)
         PH_KEY_IN: begin
            h_in = SHA1_IV;
            blk  = key ^ {64{8'h36}};
         end
         PH_KEY_OUT: begin
            h_in = SHA1_IV;
            blk  = key ^ {64{8'h5C}};
         end
         PH_INNER: begin
            h_in = istate_ff;
            if (iter_ff == 32'd1)
               blk = {salt_rev, ctr_ff, 8'h80, 344'd0, 64'd608};
            else if (mode_ff)
               blk = {u_ff, u_ff, 8'h80, 120'd0, 64'd832};
            else
               blk = {u_ff, 8'h80, 280'd0, 64'd672};
         end
         default: begin
            h_in = ostate_ff;
            blk  = {inner_ff, 8'h80, 280'd0, 64'd672};
         end
      endcase
   end

   phs_sha1_core u_core (
      .clock (clock),
      .reset (reset),
      .start (cmd.sha_go),
      .h_in  (h_in),
      .blk   (blk),
      .done  (sha_done),
      .h_out (h_out)
   );

   // settings and password
   always_ff @(posedge clock) begin
      if (reset) begin
         salt_ff  <= '0;
         iters_ff <= 32'd1000;
         mode_ff  <= 1'b0;
         for (int i = 0; i < KEY_WORDS; i++) pw_ff[i] <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SALT:  salt_ff  <= csr_wdata;
               CSR_ITERS: iters_ff <= csr_wdata[31:0];
               CSR_MODE:  mode_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.load && 32'(key_word_index) < KEY_WORDS)
            pw_ff[key_word_index] <= key_word;
      end
   end

   // stream control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff  <= 32'd1;
         ptr_ff  <= 5'(HASH_BYTES);
         rem_ff  <= '0;
         iter_ff <= 32'd1;
      end else begin
         if (cmd.restart) begin
            ctr_ff <= 32'd1;
            ptr_ff <= 5'(HASH_BYTES);
         end
         if (cmd.req_start) rem_ff <= sat_count(byte_count);
         if (cmd.blk_begin) iter_ff <= 32'd1;
         if (cmd.iter_next) iter_ff <= iter_ff + 32'd1;
         if (cmd.blk_end) begin
            ctr_ff <= ctr_ff + 32'd1;
            ptr_ff <= '0;
         end
         if (cmd.pop) begin
            ptr_ff <= ptr_ff + 5'd1;
            rem_ff <= rem_ff - 7'd1;
         end
      end
   end

   // hash results
   always_ff @(posedge clock) begin
      if (sha_done) begin
         case (cmd.phase)
            PH_KEY_IN:  istate_ff <= h_out;
            PH_KEY_OUT: ostate_ff <= h_out;
            PH_INNER:   inner_ff  <= h_out;
            default: begin
               u_ff <= h_out;
               if (iter_ff == 32'd1 || mode_ff) acc_ff <= h_out;
               else                             acc_ff <= acc_ff ^ h_out;
            end
         endcase
      end
   end

   assign shifted  = acc_ff << {ptr_ff, 3'b000};
   assign out_byte = shifted[159:152];

   assign status.sha_done  = sha_done;
   assign status.last_iter = (iter_ff >= iters_ff);
   assign status.buf_empty = (ptr_ff >= 5'(HASH_BYTES));
   assign status.last_out  = (rem_ff == 7'd1);
endmodule

// File: rtl/core/phs_ctrl.sv
// Controller state machine: decodes items, sequences HMAC compressions, emits bytes.
// Depends on phs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pbkdf2_hmac_sha1_byte_stream_defines.svh"
module phs_ctrl
   import phs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [1:0]     req_op,
   input  logic           req_cnt_zero,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output phs_cmd_type    cmd,
   input  phs_status_type status
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_GO   = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       keys_ok_ff, keys_ok_in;
   logic       req_fire;

   assign req_fire = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      keys_ok_in = keys_ok_ff;
      cmd        = '0;
      cmd.phase  = phase_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op)
                  OP_LOAD:    cmd.load = 1'b1;
                  OP_RESTART: cmd.restart = 1'b1;
                  OP_REQ: begin
                     if (!req_cnt_zero) begin
                        cmd.req_start = 1'b1;
                        keys_ok_in    = 1'b0;
                        state_in      = S_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_EMIT: begin
            if (!status.buf_empty) begin
               rsp_valid = 1'b1;
               if (rsp_ready) begin
                  cmd.pop = 1'b1;
                  if (status.last_out) state_in = S_IDLE;
               end
            end else if (keys_ok_ff) begin
               cmd.blk_begin = 1'b1;
               phase_in      = PH_INNER;
               state_in      = S_GO;
            end else begin
               phase_in = PH_KEY_IN;
               state_in = S_GO;
            end
         end
         S_GO: begin
            cmd.sha_go = 1'b1;
            state_in   = S_WAIT;
         end
         S_WAIT: begin
            if (status.sha_done) begin
               state_in = S_GO;
               case (phase_ff)
                  PH_KEY_IN: phase_in = PH_KEY_OUT;
                  PH_KEY_OUT: begin
                     keys_ok_in    = 1'b1;
                     cmd.blk_begin = 1'b1;
                     phase_in      = PH_INNER;
                  end
                  PH_INNER: phase_in = PH_OUTER;
                  default: begin
                     if (status.last_iter) begin
                        cmd.blk_end = 1'b1;
                        state_in    = S_EMIT;
                     end else begin
                        cmd.iter_next = 1'b1;
                        phase_in      = PH_INNER;
                     end
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         keys_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         keys_ok_ff <= keys_ok_in;
      end
   end

   `PHS_ASSERT_NEXT(a_req_starts_work, clock, reset,
      req_fire && req_op == OP_REQ && !req_cnt_zero, state_ff == S_EMIT)
   `PHS_ASSERT_IMPLY(a_no_accept_while_emit, clock, reset, req_ready, !rsp_valid)
   `PHS_ASSERT_NEXT(a_go_then_wait, clock, reset, cmd.sha_go,
      state_ff == S_WAIT && !status.sha_done)
endmodule

// File: rtl/core/pbkdf2_hmac_sha1_byte_stream.sv
// PBKDF2-style HMAC-SHA1 key stream generator (top level).
// Depends on phs_pkg, phs_if, phs_ctrl, phs_datapath, phs_sha1_core.
`timescale 1ns / 1ps
// Takes one request item at a time. A password load, restart or unused op
// finishes in the cycle it is accepted. A byte request first returns buffered
// leftover bytes, one per cycle when rsp is ready, starting the cycle after
// the item is accepted. Each SHA-1 compression is an issue step, 80 rounds
// at one round per cycle on the single shared compression unit, and a handoff
// step. Two compressions precompute the padded key states once per request
// that needs a fresh block, and two more are needed per HMAC iteration; a
// block runs max(iteration_count, 1) iterations before its bytes come out.
// No new item is taken until the last byte of a request has been delivered.
// Settings may only be written while idle.
module pbkdf2_hmac_sha1_byte_stream
   import phs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   phs_req_if.sink         req_bus,
   phs_rsp_if.source       rsp_bus,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [63:0]     csr_wdata
);
   phs_cmd_type    cmd;
   phs_status_type status;

   // controller sequences the work, datapath holds the data registers and the hash unit
   phs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_ready    (req_bus.ready),
      .req_op       (req_bus.op),
      .req_cnt_zero (req_bus.byte_count == 7'd0),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .cmd          (cmd),
      .status       (status)
   );

   phs_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .key_word_index (req_bus.key_word_index),
      .key_word       (req_bus.key_word),
      .byte_count     (req_bus.byte_count),
      .out_byte       (rsp_bus.out_byte)
   );

   // last byte of the request when one byte remains
   assign rsp_bus.last_byte = status.last_out;
endmodule

// File: verif/pbkdf2_hmac_sha1_byte_stream_test.sv
// Self-checking testbench for the PBKDF2 HMAC-SHA1 byte stream block.
// Depends on phs_pkg, phs_if and the block's RTL; has its own SHA-1/HMAC model.
`timescale 1ns / 1ps
module pbkdf2_hmac_sha1_byte_stream_test;
   import phs_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [2:0]  idx;
      logic [63:0] word;
      logic [6:0]  count;
      bit          silent;   // row must give no bytes
   } stream_item_type;

   typedef struct {
      logic [7:0] b;
      logic       last;
   } key_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_SALT;
   logic [63:0] csr_wdata = '0;

   phs_req_if req_ch ();
   phs_rsp_if rsp_ch ();

   pbkdf2_hmac_sha1_byte_stream dut (
      .clock(clock), .reset(reset), .req_bus(req_ch), .rsp_bus(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow state of the key stream
   logic [63:0] pw_words [0:7];
   logic [31:0] blk_ctr;
   logic [159:0] tail_bytes;     // unused tail, byte 0 in MSBs
   int unsigned tail_start, tail_end;
   logic [63:0] salt_reg;
   logic [31:0] iter_reg;
   logic        chain_reg;

   key_byte_type pending_bytes[$];
   int  errors = 0;
   bit  quiet = 0;          // no idling on either side
   bit  long_hold = 0;      // ask the receiver for one long stall
   bit  src_idle = 1;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [159:0] sha1_round16(input logic [159:0] h,
                                                 input logic [511:0] blk);
      logic [31:0] w [0:79];
      logic [31:0] a, b, c, d, e, f, kc, t;
      int i;
      for (i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
      for (i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
      for (i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); kc = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; kc = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); kc = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; kc = 32'hCA62C1D6;
         end
         t = rol(a, 5) + f + e + kc + w[i];
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
   endfunction

   // m holds len bytes from the MSB end, zero beyond; len <= 104
   function automatic logic [159:0] sha1_digest(input logic [1023:0] m, input int len);
      logic [1023:0] p;
      logic [159:0] h;
      int total;
      p = m;
      p[1023 - 8*len -: 8] = 8'h80;
      total = ((len + 8) / 64 + 1) * 64;
      p[1023 - 8*(total - 8) -: 64] = 64'(len) * 64'd8;
      h = sha1_round16(SHA1_IV, p[1023:512]);
      if (total == 128) h = sha1_round16(h, p[511:0]);
      return h;
   endfunction

   // msg: up to 40 bytes from the MSB end
   function automatic logic [159:0] hmac_tag(input logic [319:0] msg, input int len);
      logic [511:0] key;
      logic [159:0] inner;
      key = {pw_words[0], pw_words[1], pw_words[2], pw_words[3],
             pw_words[4], pw_words[5], pw_words[6], pw_words[7]};
      inner = sha1_digest({key ^ {64{8'h36}}, msg, 192'b0}, 64 + len);
      return sha1_digest({key ^ {64{8'h5C}}, inner, 352'b0}, 84);
   endfunction

   function automatic logic [159:0] next_key_block();
      logic [319:0] msg;
      logic [159:0] u, acc;
      logic [63:0] n;
      int i;
      msg = '0;
      for (i = 0; i < 8; i++) msg[319 - 8*i -: 8] = salt_reg[8*i +: 8];
      msg[255:224] = blk_ctr;
      u = hmac_tag(msg, 12);
      acc = u;
      for (n = 2; n <= 64'(iter_reg); n++) begin
         if (chain_reg) begin
            u = hmac_tag({u, u}, 40);
            acc = u;
         end else begin
            u = hmac_tag({u, 160'b0}, 20);
            acc ^= u;
         end
      end
      blk_ctr += 32'd1;
      return acc;
   endfunction

   function automatic void restart_stream();
      tail_bytes = '0; blk_ctr = 32'd1; tail_start = 0; tail_end = 0;
   endfunction

   // queue the bytes one accepted item must produce; returns how many
   function automatic int predict_item(input stream_item_type it);
      int unsigned cnt, done, avail, take, need, k;
      logic [7:0] got [0:63];
      logic [159:0] blk;
      key_byte_type kb;
      done = 0;
      if (it.op == OP_LOAD) begin
         pw_words[it.idx] = it.word;
         return 0;
      end
      if (it.op == OP_RESTART) begin
         restart_stream();
         return 0;
      end
      if (it.op != OP_REQ) return 0;
      cnt = (it.count > 7'(MAX_REQUEST_BYTES)) ? MAX_REQUEST_BYTES : it.count;
      if (cnt == 0) return 0;
      avail = (tail_end > tail_start && tail_end <= HASH_BYTES) ? tail_end - tail_start : 0;
      if (avail > 0) begin
         take = (cnt < avail) ? cnt : avail;
         for (k = 0; k < take; k++) got[k] = tail_bytes[159 - 8*(tail_start + k) -: 8];
         done = take;
         if (cnt < avail) tail_start += cnt;
         else begin
            tail_start = 0; tail_end = 0;
         end
      end else begin
         tail_start = 0; tail_end = 0;
      end
      while (done < cnt) begin
         need = cnt - done;
         blk = next_key_block();
         if (need <= HASH_BYTES) begin
            for (k = 0; k < need; k++) got[done + k] = blk[159 - 8*k -: 8];
            done += need;
            tail_bytes = blk << (8 * need);
            tail_start = 0;
            tail_end = HASH_BYTES - need;
         end else begin
            for (k = 0; k < HASH_BYTES; k++) got[done + k] = blk[159 - 8*k -: 8];
            done += HASH_BYTES;
         end
      end
      for (k = 0; k < cnt; k++) begin
         kb.b = got[k];
         kb.last = (k + 1 == cnt);
         pending_bytes.push_back(kb);
      end
      return cnt;
   endfunction

   // result side: compare each delivered byte with the oldest expectation
   always @(posedge clock) begin
      key_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual %h last %b",
                     $time, rsp_ch.out_byte, rsp_ch.last_byte);
            errors++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_ch.out_byte !== want.b) begin
               $display("%0t: out_byte mismatch: expected %h, actual %h",
                        $time, want.b, rsp_ch.out_byte);
               errors++;
            end
            if (rsp_ch.last_byte !== want.last) begin
               $display("%0t: last_byte mismatch: expected %b, actual %b",
                        $time, want.last, rsp_ch.last_byte);
               errors++;
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 0;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_item(input stream_item_type it);
      int n, produced;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         n = $urandom_range(1, 17);
         repeat (n) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= it.op;
      req_ch.key_word_index <= it.idx;
      req_ch.key_word <= it.word;
      req_ch.byte_count <= it.count;
      do @(posedge clock); while (!req_ch.ready);
      produced = predict_item(it);
      if (it.silent && produced != 0) begin
         $display("%0t: row should give no bytes: expected 0, actual %0d", $time, produced);
         errors++;
      end
   endtask

   // settings change only once the stream has drained
   task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
      req_ch.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SALT:  salt_reg = val;
         CSR_ITERS: iter_reg = val[31:0];
         CSR_MODE:  chain_reg = val[0];
         default: ;
      endcase
   endtask

   function automatic stream_item_type rand_item();
      stream_item_type it;
      int r;
      r = $urandom_range(0, 99);
      it.op = (r < 60) ? OP_REQ : (r < 85) ? OP_LOAD : (r < 94) ? OP_RESTART : OP_UNUSED;
      it.idx = 3'($urandom);
      it.word = {$urandom, $urandom};
      r = $urandom_range(0, 19);
      it.count = (r == 0) ? 7'd0 : (r == 1) ? 7'($urandom_range(65, 127))
                                            : 7'($urandom_range(1, 64));
      it.silent = 0;
      return it;
   endfunction

   stream_item_type directed [] = '{
      '{OP_LOAD,    3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0,  1},
      '{OP_LOAD,    3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0,  1},
      '{OP_LOAD,    3'd3, 64'h0123_4567_89AB_CDEF, 7'd0,  1},
      '{OP_REQ,     3'd0, 64'h0,                   7'd1,  0},
      '{OP_REQ,     3'd0, 64'h0,                   7'd19, 0},   // drains tail exactly
      '{OP_REQ,     3'd0, 64'h0,                   7'd20, 0},   // one whole block
      '{OP_REQ,     3'd0, 64'h0,                   7'd0,  1},   // zero count
      '{OP_REQ,     3'd0, 64'h0,                   7'd64, 0},
      '{OP_REQ,     3'd0, 64'h0,                   7'd127, 0},  // saturates
      '{OP_REQ,     3'd0, 64'h0,                   7'd65, 0},
      '{OP_UNUSED,  3'd5, 64'hDEAD_BEEF_0000_0001, 7'd9,  1},
      '{OP_REQ,     3'd0, 64'h0,                   7'd3,  0},
      '{OP_LOAD,    3'd7, 64'h0,                   7'd0,  1},   // load keeps the stream
      '{OP_REQ,     3'd0, 64'h0,                   7'd21, 0},
      '{OP_RESTART, 3'd0, 64'h0,                   7'd0,  1},
      '{OP_REQ,     3'd0, 64'h0,                   7'd5,  0},
      '{OP_RESTART, 3'd0, 64'h0,                   7'd0,  1},
      '{OP_REQ,     3'd0, 64'h0,                   7'd64, 0}
   };

   initial begin
      int i, j;
      for (i = 0; i < 8; i++) pw_words[i] = '0;
      restart_stream();
      salt_reg = '0; iter_reg = 32'd1000; chain_reg = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_LOAD;
      req_ch.key_word_index <= '0;
      req_ch.key_word <= '0;
      req_ch.byte_count <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes written while nothing runs; the huge count is never used
      write_reg(CSR_ITERS, 64'hFFFF_FFFF);
      write_reg(CSR_MODE, 64'd1);
      write_reg(CSR_SALT, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_ITERS, 64'd1);
      write_reg(CSR_MODE, 64'd0);
      foreach (directed[i]) send_item(directed[i]);

      write_reg(CSR_ITERS, 64'd0);
      write_reg(CSR_SALT, 64'd0);
      write_reg(CSR_MODE, 64'd1);
      for (i = 0; i < 4; i++) send_item(directed[3 + i]);

      // random part in phases of settings
      for (j = 0; j < 5; j++) begin
         write_reg(CSR_SALT, {$urandom, $urandom});
         write_reg(CSR_ITERS, 64'($urandom_range(0, 3)));
         write_reg(CSR_MODE, 64'($urandom_range(0, 1)));
         if (j == 1) long_hold = 1;
         if (j == 4) quiet = 1;
         for (i = 0; i < 20; i++) send_item(rand_item());
      end

      req_ch.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && pending_bytes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/phs_pkg.sv
rtl/core/phs_if.sv
rtl/core/phs_sha1_core.sv
rtl/core/phs_datapath.sv
rtl/core/phs_ctrl.sv
rtl/core/pbkdf2_hmac_sha1_byte_stream.sv
verif/pbkdf2_hmac_sha1_byte_stream_test.sv
